[hdl/ptss_pkg.sv]
package ptss_pkg;

  localparam int NumProcsDef = 8;
  localparam int NumSemsDef  = 8;

  localparam int UpcW = 5;
  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_SCHEDULE = 3'd0,
    OP_FORK     = 3'd1,
    OP_WAIT     = 3'd2,
    OP_EXIT     = 3'd3,
    OP_GETSEM   = 3'd4,
    OP_SEM_P    = 3'd5,
    OP_SEM_V    = 3'd6,
    OP_FREE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    PS_READY   = 2'd0,
    PS_RUNNING = 2'd1,
    PS_BLOCKED = 2'd2,
    PS_DONE    = 2'd3
  } pst_e;

  typedef enum logic [1:0] {
    OC_OK   = 2'd0,
    OC_NONE = 2'd1,
    OC_FULL = 2'd2
  } outcome_e;

  // datapath action of one microstep
  typedef enum logic [4:0] {
    A_NOP, A_IDLE, A_EMIT,
    A_RD_PCUR, A_SCH_INIT, A_SCAN_RD, A_SCAN_TST, A_SCH_NONE,
    A_FORK, A_BLOCK,
    A_RD_PAR, A_EXIT_CUR, A_EXIT_PAR,
    A_GS_INIT, A_GS_RD, A_GS_TST, A_GS_NEXT,
    A_SEM_CHK, A_SEM_RD, A_P_UPD, A_V_UPD, A_V_WAKE, A_FREE
  } act_e;

  // sequencing: how the next microaddress is chosen
  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_HIT, C_MISS, C_CNT_NZ, C_WAIT, C_DISPATCH
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  target;
  } uword_t;

  // microprogram addresses
  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_FINISH   = 5'd1;
  localparam upc_t U_SCH_RD   = 5'd2;
  localparam upc_t U_SCH_INIT = 5'd3;
  localparam upc_t U_SCAN_RD  = 5'd4;
  localparam upc_t U_SCAN_TST = 5'd5;
  localparam upc_t U_SCAN_LP  = 5'd6;
  localparam upc_t U_SCH_NONE = 5'd7;
  localparam upc_t U_FORK     = 5'd8;
  localparam upc_t U_WAIT     = 5'd9;
  localparam upc_t U_EXIT_RD  = 5'd10;
  localparam upc_t U_EXIT_CUR = 5'd11;
  localparam upc_t U_EXIT_PAR = 5'd12;
  localparam upc_t U_GS_INIT  = 5'd13;
  localparam upc_t U_GS_RD    = 5'd14;
  localparam upc_t U_GS_TST   = 5'd15;
  localparam upc_t U_GS_NEXT  = 5'd16;
  localparam upc_t U_GS_END   = 5'd17;
  localparam upc_t U_P_CHK    = 5'd18;
  localparam upc_t U_P_RD     = 5'd19;
  localparam upc_t U_P_UPD    = 5'd20;
  localparam upc_t U_P_BLK    = 5'd21;
  localparam upc_t U_V_CHK    = 5'd22;
  localparam upc_t U_V_RD     = 5'd23;
  localparam upc_t U_V_UPD    = 5'd24;
  localparam upc_t U_V_WAKE   = 5'd25;
  localparam upc_t U_F_CHK    = 5'd26;
  localparam upc_t U_F_CLR    = 5'd27;

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      U_IDLE:     w = '{A_IDLE,     C_DISPATCH, U_IDLE};
      U_FINISH:   w = '{A_EMIT,     C_WAIT,     U_IDLE};
      U_SCH_RD:   w = '{A_RD_PCUR,  C_NEXT,     U_IDLE};
      U_SCH_INIT: w = '{A_SCH_INIT, C_HIT,      U_SCH_NONE};
      U_SCAN_RD:  w = '{A_SCAN_RD,  C_NEXT,     U_IDLE};
      U_SCAN_TST: w = '{A_SCAN_TST, C_HIT,      U_FINISH};
      U_SCAN_LP:  w = '{A_NOP,      C_CNT_NZ,   U_SCAN_RD};
      U_SCH_NONE: w = '{A_SCH_NONE, C_ALWAYS,   U_FINISH};
      U_FORK:     w = '{A_FORK,     C_ALWAYS,   U_FINISH};
      U_WAIT:     w = '{A_BLOCK,    C_ALWAYS,   U_FINISH};
      U_EXIT_RD:  w = '{A_RD_PAR,   C_NEXT,     U_IDLE};
      U_EXIT_CUR: w = '{A_EXIT_CUR, C_NEXT,     U_IDLE};
      U_EXIT_PAR: w = '{A_EXIT_PAR, C_ALWAYS,   U_FINISH};
      U_GS_INIT:  w = '{A_GS_INIT,  C_NEXT,     U_IDLE};
      U_GS_RD:    w = '{A_GS_RD,    C_NEXT,     U_IDLE};
      U_GS_TST:   w = '{A_GS_TST,   C_HIT,      U_FINISH};
      U_GS_NEXT:  w = '{A_GS_NEXT,  C_HIT,      U_GS_RD};
      U_GS_END:   w = '{A_NOP,      C_ALWAYS,   U_FINISH};
      U_P_CHK:    w = '{A_SEM_CHK,  C_HIT,      U_FINISH};
      U_P_RD:     w = '{A_SEM_RD,   C_NEXT,     U_IDLE};
      U_P_UPD:    w = '{A_P_UPD,    C_MISS,     U_FINISH};
      U_P_BLK:    w = '{A_BLOCK,    C_ALWAYS,   U_FINISH};
      U_V_CHK:    w = '{A_SEM_CHK,  C_HIT,      U_FINISH};
      U_V_RD:     w = '{A_SEM_RD,   C_NEXT,     U_IDLE};
      U_V_UPD:    w = '{A_V_UPD,    C_MISS,     U_FINISH};
      U_V_WAKE:   w = '{A_V_WAKE,   C_ALWAYS,   U_FINISH};
      U_F_CHK:    w = '{A_SEM_CHK,  C_HIT,      U_FINISH};
      U_F_CLR:    w = '{A_FREE,     C_ALWAYS,   U_FINISH};
      default:    w = '{A_NOP,      C_ALWAYS,   U_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t entry(op_e op);
    upc_t a;
    unique case (op)
      OP_SCHEDULE: a = U_SCH_RD;
      OP_FORK:     a = U_FORK;
      OP_WAIT:     a = U_WAIT;
      OP_EXIT:     a = U_EXIT_RD;
      OP_GETSEM:   a = U_GS_INIT;
      OP_SEM_P:    a = U_P_CHK;
      OP_SEM_V:    a = U_V_CHK;
      OP_FREE:     a = U_F_CHK;
      default:     a = U_IDLE;
    endcase
    return a;
  endfunction

endpackage

[hdl/process_table_scheduler_semaphores_unit.sv]
// Process table scheduler with counting semaphores.
// Input channel (in_valid_i/in_ready_o) carries one item: op_i and sem_index_i.
// Output channel (out_valid_o/out_ready_i) returns exactly one result item per
// input item: outcome_o, running_process_o, result_index_o, caller_blocked_o.
// cfg_we_i/cfg_wdata_i write first_user_process; write only while idle.
// Ops run one at a time on a microcoded sequencer.
// The scans are bound by the single registered read port of the process and
// semaphore tables: each probed entry costs a read step, a test step and
// a loop step. A new item is taken in the cycle after the
// previous result is loaded into the output register.
// If the receiver stalls, the result waits in the output register; the next
// item is still accepted and runs, and only its own result step waits.
// Reset: processes 1 and 2 ready, others done, current process 0, highest
// process 2, all semaphores cleared, first_user_process 1. Reset takes effect
// at once through per-entry valid bits; there is no clearing pass.
module process_table_scheduler_semaphores_unit import ptss_pkg::*; #(
  parameter int NUM_PROCS = NumProcsDef,
  parameter int NUM_SEMS  = NumSemsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [2:0] sem_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] outcome_o,
  output logic [2:0] running_process_o,
  output logic [2:0] result_index_o,
  output logic       caller_blocked_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);

  localparam int PW       = $clog2(NUM_PROCS);
  localparam int SW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int CW       = (PW > 3) ? PW : 3;
  localparam int WQ_DEPTH = NUM_SEMS * (2 ** PW);

  typedef logic [PW-1:0]     pid_t;
  typedef logic [SW-1:0]     sid_t;
  typedef logic [PW:0]       span_t;
  typedef logic [CW:0]       wide_t;
  typedef logic signed [4:0] cnt_t;

  typedef struct packed {
    cnt_t count;
    logic in_use;
    pid_t head;
    pid_t tail;
  } sem_t;

  localparam pid_t       PID_LAST  = pid_t'(NUM_PROCS - 1);
  localparam sid_t       SID_LAST  = sid_t'(NUM_SEMS - 1);
  localparam pid_t       HIGH_RST  = (NUM_PROCS > 2) ? pid_t'(2) : PID_LAST;
  localparam logic [6:0] SEM_LIMIT = 7'(NUM_SEMS);
  localparam cnt_t       CNT_MIN   = 5'sb10000;
  localparam cnt_t       CNT_MAX   = 5'sb01111;

  function automatic pst_e pst_init(pid_t p);
    return (int'(p) == 1 || int'(p) == 2) ? PS_READY : PS_DONE;
  endfunction

  function automatic pid_t pid_inc(pid_t p);
    return (p == PID_LAST) ? '0 : p + 1'b1;
  endfunction

  // sequencer and architectural state
  upc_t       upc_q, upc_d;
  logic [2:0] first_q;
  pid_t       cur_q, cur_d;
  pid_t       high_q, high_d;

  // working registers
  logic [2:0] sem_q, sem_d;
  pid_t       ptr_q, ptr_d;
  span_t      cnt_q, cnt_d;
  sid_t       si_q, si_d;
  outcome_e   res_outcome_q, res_outcome_d;
  logic [2:0] res_index_q, res_index_d;
  logic       res_blocked_q, res_blocked_d;

  // output register
  logic       out_valid_q;
  outcome_e   out_outcome_q;
  logic [2:0] out_running_q, out_index_q;
  logic       out_blocked_q;

  // process status table
  pst_e             pst_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] pst_vld_q;
  pst_e             pst_rd_q;
  logic             pst_we, pst_re;
  pid_t             pst_wa, pst_ra;
  pst_e             pst_wd;

  // parent table
  pid_t             par_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] par_vld_q;
  pid_t             par_rd_q;
  logic             par_we, par_re;
  pid_t             par_wa, par_wd;

  // semaphore records, addressed by si_q
  sem_t             sem_mem [NUM_SEMS];
  logic [NUM_SEMS-1:0] sem_vld_q;
  sem_t             sem_rd_q;
  logic             sem_we, sem_re;
  sem_t             sem_wd;

  // wait rings, one slice of 2**PW entries per semaphore
  pid_t             wq_mem [WQ_DEPTH];
  pid_t             wq_rd_q;
  logic             wq_we, wq_re;
  logic [SW+PW-1:0] wq_wa, wq_ra;
  pid_t             wq_wd;

  uword_t uw;
  logic   hit;
  logic   out_free;
  logic   emit;
  wide_t  first_x, high_x, next_x, start_x, span_x;
  cnt_t   new_cnt;

  assign in_ready_o = (upc_q == U_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    uw            = ucode(upc_q);
    hit           = 1'b0;
    emit          = 1'b0;
    upc_d         = upc_q;
    cur_d         = cur_q;
    high_d        = high_q;
    sem_d         = sem_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    si_d          = si_q;
    res_outcome_d = res_outcome_q;
    res_index_d   = res_index_q;
    res_blocked_d = res_blocked_q;
    pst_we        = 1'b0;
    pst_re        = 1'b0;
    pst_wa        = cur_q;
    pst_ra        = cur_q;
    pst_wd        = PS_READY;
    par_we        = 1'b0;
    par_re        = 1'b0;
    par_wa        = high_q;
    par_wd        = cur_q;
    sem_we        = 1'b0;
    sem_re        = 1'b0;
    sem_wd        = sem_rd_q;
    wq_we         = 1'b0;
    wq_re         = 1'b0;
    wq_wa         = {si_q, sem_rd_q.tail};
    wq_ra         = {si_q, sem_rd_q.head};
    wq_wd         = cur_q;
    new_cnt       = sem_rd_q.count;

    // round-robin start point and span
    first_x = wide_t'(first_q);
    high_x  = wide_t'(high_q);
    next_x  = wide_t'(cur_q) + 1'b1;
    span_x  = high_x - first_x + 1'b1;
    if (cur_q == '0 || next_x < first_x || next_x > high_x) begin
      start_x = first_x;
    end else begin
      start_x = next_x;
    end

    unique case (uw.act)
      A_IDLE: begin
        sem_d         = sem_index_i;
        res_outcome_d = OC_OK;
        res_index_d   = '0;
        res_blocked_d = 1'b0;
      end
      A_EMIT: begin
        hit  = out_free;
        emit = out_free;
      end
      A_RD_PCUR: begin
        pst_re = 1'b1;
      end
      A_SCH_INIT: begin
        // a running current process goes back to ready first
        if (pst_rd_q == PS_RUNNING) begin
          pst_we = 1'b1;
          pst_wd = PS_READY;
        end
        ptr_d = pid_t'(start_x);
        cnt_d = span_t'(span_x);
        hit   = first_x > high_x;
      end
      A_SCAN_RD: begin
        pst_re = 1'b1;
        pst_ra = ptr_q;
      end
      A_SCAN_TST: begin
        if (pst_rd_q == PS_READY) begin
          hit    = 1'b1;
          pst_we = 1'b1;
          pst_wa = ptr_q;
          pst_wd = PS_RUNNING;
          cur_d  = ptr_q;
        end else begin
          ptr_d = (ptr_q == high_q) ? pid_t'(first_q) : ptr_q + 1'b1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      A_SCH_NONE: begin
        cur_d         = '0;
        res_outcome_d = OC_NONE;
      end
      A_FORK: begin
        if (high_q == PID_LAST) begin
          res_outcome_d = OC_FULL;
        end else begin
          high_d      = high_q + 1'b1;
          pst_we      = 1'b1;
          pst_wa      = high_q + 1'b1;
          pst_wd      = PS_READY;
          par_we      = 1'b1;
          par_wa      = high_q + 1'b1;
          res_index_d = 3'(high_q + 1'b1);
        end
      end
      A_BLOCK: begin
        pst_we        = 1'b1;
        pst_wd        = PS_BLOCKED;
        res_blocked_d = 1'b1;
      end
      A_RD_PAR: begin
        par_re = 1'b1;
      end
      A_EXIT_CUR: begin
        pst_we = 1'b1;
        pst_wd = PS_DONE;
      end
      A_EXIT_PAR: begin
        // parent write comes last so it wins when parent == current
        pst_we = 1'b1;
        pst_wa = par_rd_q;
        pst_wd = PS_READY;
      end
      A_GS_INIT: begin
        si_d          = '0;
        res_outcome_d = OC_NONE;
      end
      A_GS_RD: begin
        sem_re = 1'b1;
      end
      A_GS_TST: begin
        if (!sem_rd_q.in_use) begin
          hit           = 1'b1;
          sem_we        = 1'b1;
          sem_wd.in_use = 1'b1;
          res_outcome_d = OC_OK;
          res_index_d   = 3'(si_q);
        end
      end
      A_GS_NEXT: begin
        hit  = si_q != SID_LAST;
        si_d = si_q + 1'b1;
      end
      A_SEM_CHK: begin
        hit  = {4'b0000, sem_q} >= SEM_LIMIT;
        si_d = sid_t'(sem_q);
      end
      A_SEM_RD: begin
        sem_re = 1'b1;
      end
      A_P_UPD: begin
        new_cnt      = (sem_rd_q.count != CNT_MIN) ? sem_rd_q.count - 1'b1 : sem_rd_q.count;
        sem_we       = 1'b1;
        sem_wd.count = new_cnt;
        if (new_cnt[4]) begin
          hit         = 1'b1;
          sem_wd.tail = pid_inc(sem_rd_q.tail);
          wq_we       = 1'b1;
        end
      end
      A_V_UPD: begin
        new_cnt      = (sem_rd_q.count != CNT_MAX) ? sem_rd_q.count + 1'b1 : sem_rd_q.count;
        sem_we       = 1'b1;
        sem_wd.count = new_cnt;
        if (new_cnt[4] || new_cnt == '0) begin
          hit         = 1'b1;
          sem_wd.head = pid_inc(sem_rd_q.head);
          wq_re       = 1'b1;
        end
      end
      A_V_WAKE: begin
        pst_we = 1'b1;
        pst_wa = wq_rd_q;
        pst_wd = PS_READY;
      end
      A_FREE: begin
        sem_we = 1'b1;
        sem_wd = '0;
      end
      default: begin
      end
    endcase

    unique case (uw.cond)
      C_NEXT:     upc_d = upc_q + 1'b1;
      C_ALWAYS:   upc_d = uw.target;
      C_HIT:      upc_d = hit ? uw.target : upc_q + 1'b1;
      C_MISS:     upc_d = hit ? upc_q + 1'b1 : uw.target;
      C_CNT_NZ:   upc_d = (cnt_q != '0) ? uw.target : upc_q + 1'b1;
      C_WAIT:     upc_d = hit ? uw.target : upc_q;
      C_DISPATCH: upc_d = in_valid_i ? entry(op_e'(op_i)) : upc_q;
      default:    upc_d = U_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      first_q     <= 3'd1;
      cur_q       <= '0;
      high_q      <= HIGH_RST;
      out_valid_q <= 1'b0;
      pst_vld_q   <= '0;
      par_vld_q   <= '0;
      sem_vld_q   <= '0;
    end else begin
      upc_q  <= upc_d;
      cur_q  <= cur_d;
      high_q <= high_d;
      if (cfg_we_i) begin
        first_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pst_we) begin
        pst_vld_q[pst_wa] <= 1'b1;
      end
      if (par_we) begin
        par_vld_q[par_wa] <= 1'b1;
      end
      if (sem_we) begin
        sem_vld_q[si_q] <= 1'b1;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    sem_q         <= sem_d;
    ptr_q         <= ptr_d;
    cnt_q         <= cnt_d;
    si_q          <= si_d;
    res_outcome_q <= res_outcome_d;
    res_index_q   <= res_index_d;
    res_blocked_q <= res_blocked_d;
    if (emit) begin
      out_outcome_q <= res_outcome_q;
      out_running_q <= 3'(cur_q);
      out_index_q   <= res_index_q;
      out_blocked_q <= res_blocked_q;
    end
  end

  // tables: one write and one registered read per cycle each;
  // an entry never written in the status, parent or semaphore table reads as its reset value
  always_ff @(posedge clk_i) begin
    if (pst_we) begin
      pst_mem[pst_wa] <= pst_wd;
    end
    if (pst_re) begin
      pst_rd_q <= pst_vld_q[pst_ra] ? pst_mem[pst_ra] : pst_init(pst_ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (par_re) begin
      par_rd_q <= par_vld_q[cur_q] ? par_mem[cur_q] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sem_we) begin
      sem_mem[si_q] <= sem_wd;
    end
    if (sem_re) begin
      sem_rd_q <= sem_vld_q[si_q] ? sem_mem[si_q] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wq_we) begin
      wq_mem[wq_wa] <= wq_wd;
    end
    if (wq_re) begin
      wq_rd_q <= wq_mem[wq_ra];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = out_outcome_q;
  assign running_process_o = out_running_q;
  assign result_index_o    = out_index_q;
  assign caller_blocked_o  = out_blocked_q;

endmodule

[hdl/ptss_checker.sv]
module ptss_checker import ptss_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] outcome_o,
  input logic [2:0] result_index_o,
  input logic       caller_blocked_o
);

  // one item in flight: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  // no op finishes in the cycle right after its accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OC_OK || outcome_o == OC_NONE || outcome_o == OC_FULL))
    else $error("undefined outcome code");

  // a blocking op never allocates anything and never fails
  a_blocked_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && caller_blocked_o) |-> (outcome_o == OC_OK && result_index_o == '0))
    else $error("blocked caller with nonzero outcome or index");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(outcome_o)
      && $stable(result_index_o) && $stable(caller_blocked_o)))
    else $error("stalled result changed");

endmodule

bind process_table_scheduler_semaphores_unit ptss_checker u_ptss_checker (.*);

[test/process_table_scheduler_semaphores_unit_checker.sv]
`timescale 1ns / 100ps

module process_table_scheduler_semaphores_unit_checker import ptss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  op_i,
  input  logic [2:0]  sem_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  outcome_i,
  input  logic [2:0]  running_process_i,
  input  logic [2:0]  result_index_i,
  input  logic        caller_blocked_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    outcome_e   outcome;
    logic [2:0] running;
    logic [2:0] index;
    logic       blocked;
  } syscall_result_t;

  // shadow copy of the process table and semaphores
  pst_e              proc_st  [NumProcsDef];
  logic [2:0]        parent   [NumProcsDef];
  logic [2:0]        cur_proc;
  logic [2:0]        top_proc;
  logic [2:0]        first_user;
  logic signed [4:0] sem_cnt  [NumSemsDef];
  logic              sem_used [NumSemsDef];
  logic [2:0]        ring_head[NumSemsDef];
  logic [2:0]        ring_tail[NumSemsDef];
  logic [2:0]        ring     [NumSemsDef][NumProcsDef];

  syscall_result_t result_q[$];
  syscall_result_t want, got;

  initial fail_count_o = 0;

  task automatic report_mismatch(string what);
    $display("ERROR %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void clear_tables();
    for (int i = 0; i < NumProcsDef; i++) begin
      proc_st[i] = (i == 1 || i == 2) ? PS_READY : PS_DONE;
      parent[i]  = '0;
    end
    for (int i = 0; i < NumSemsDef; i++) begin
      sem_cnt[i]   = '0;
      sem_used[i]  = 1'b0;
      ring_head[i] = '0;
      ring_tail[i] = '0;
      for (int j = 0; j < NumProcsDef; j++) ring[i][j] = '0;
    end
    cur_proc   = '0;
    top_proc   = 3'd2;
    first_user = 3'd1;
  endfunction

  // round robin over first_user..top_proc, starting after the current process
  function automatic outcome_e pick_next_proc();
    int nxt;
    int span;
    if (proc_st[cur_proc] == PS_RUNNING) proc_st[cur_proc] = PS_READY;
    if (first_user > top_proc) begin
      cur_proc = '0;
      return OC_NONE;
    end
    span = int'(top_proc) - int'(first_user) + 1;
    nxt  = int'(cur_proc) + 1;
    if (cur_proc == 0 || nxt < int'(first_user) || nxt > int'(top_proc)) nxt = int'(first_user);
    for (int k = 0; k < span; k++) begin
      if (proc_st[nxt] == PS_READY) begin
        proc_st[nxt] = PS_RUNNING;
        cur_proc     = nxt[2:0];
        return OC_OK;
      end
      nxt = (nxt >= int'(top_proc)) ? int'(first_user) : nxt + 1;
    end
    cur_proc = '0;
    return OC_NONE;
  endfunction

  function automatic syscall_result_t run_syscall(op_e op, logic [2:0] s);
    syscall_result_t r;
    logic            sem_ok;
    r      = '{OC_OK, 3'd0, 3'd0, 1'b0};
    sem_ok = int'(s) < NumSemsDef;
    case (op)
      OP_SCHEDULE: r.outcome = pick_next_proc();
      OP_FORK: begin
        if (int'(top_proc) + 1 >= NumProcsDef) begin
          r.outcome = OC_FULL;
        end else begin
          top_proc          = top_proc + 3'd1;
          parent[top_proc]  = cur_proc;
          proc_st[top_proc] = PS_READY;
          r.index           = top_proc;
        end
      end
      OP_WAIT: begin
        proc_st[cur_proc] = PS_BLOCKED;
        r.blocked         = 1'b1;
      end
      OP_EXIT: begin
        proc_st[cur_proc]         = PS_DONE;
        proc_st[parent[cur_proc]] = PS_READY;
      end
      OP_GETSEM: begin
        r.outcome = OC_NONE;
        for (int i = 0; i < NumSemsDef; i++) begin
          if (!sem_used[i]) begin
            sem_used[i] = 1'b1;
            r.index     = i[2:0];
            r.outcome   = OC_OK;
            break;
          end
        end
      end
      OP_SEM_P: begin
        if (sem_ok) begin
          if (sem_cnt[s] > -16) sem_cnt[s] = sem_cnt[s] - 5'sd1;
          if (sem_cnt[s] < 0) begin
            proc_st[cur_proc]      = PS_BLOCKED;
            ring[s][ring_tail[s]]  = cur_proc;
            ring_tail[s]           = ring_tail[s] + 3'd1;
            r.blocked              = 1'b1;
          end
        end
      end
      OP_SEM_V: begin
        if (sem_ok) begin
          if (sem_cnt[s] < 15) sem_cnt[s] = sem_cnt[s] + 5'sd1;
          if (sem_cnt[s] <= 0) begin
            proc_st[ring[s][ring_head[s]]] = PS_READY;
            ring_head[s]                   = ring_head[s] + 3'd1;
          end
        end
      end
      OP_FREE: begin
        if (sem_ok) begin
          sem_cnt[s]   = '0;
          sem_used[s]  = 1'b0;
          ring_head[s] = '0;
          ring_tail[s] = '0;
        end
      end
      default: ;
    endcase
    r.running = cur_proc;
    return r;
  endfunction

  // results are checked before the same edge's new item is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tables();
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{outcome_e'(outcome_i), running_process_i, result_index_i, caller_blocked_i};
        if (result_q.size() == 0) begin
          report_mismatch("result item with no operation outstanding");
        end else begin
          want = result_q.pop_front();
          if (got.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, expected %0d", got.outcome, want.outcome));
          if (got.running !== want.running)
            report_mismatch($sformatf("running_process %0d, expected %0d",
                                      got.running, want.running));
          if (got.index !== want.index)
            report_mismatch($sformatf("result_index %0d, expected %0d", got.index, want.index));
          if (got.blocked !== want.blocked)
            report_mismatch($sformatf("caller_blocked %0d, expected %0d",
                                      got.blocked, want.blocked));
        end
      end
      if (cfg_we_i) first_user = cfg_wdata_i;
      if (in_valid_i && in_ready_i) result_q.push_back(run_syscall(op_e'(op_i), sem_index_i));
    end
    pending_o = result_q.size();
  end

endmodule

[test/process_table_scheduler_semaphores_unit_tb.sv]
`timescale 1ns / 100ps

module process_table_scheduler_semaphores_unit_tb import ptss_pkg::*;;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] op_i;
  logic [2:0] sem_index_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] outcome_o;
  logic [2:0] running_process_o;
  logic [2:0] result_index_o;
  logic       caller_blocked_o;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending;

  // pacing knobs: percent of cycles the sender holds off / the receiver stalls
  int unsigned gap_pct   = 33;
  int unsigned stall_pct = 77;
  int unsigned sent      = 0;
  int unsigned n_directed;

  // first_user_process per random segment; the extremes 1 and 7 included
  logic [2:0] fup_plan [6] = '{3'd3, 3'd7, 3'd1, 3'd2, 3'd5, 3'd4};

  process_table_scheduler_semaphores_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .sem_index_i       (sem_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_o         (outcome_o),
    .running_process_o (running_process_o),
    .result_index_o    (result_index_o),
    .caller_blocked_o  (caller_blocked_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  process_table_scheduler_semaphores_unit_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .op_i              (op_i),
    .sem_index_i       (sem_index_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_i         (outcome_o),
    .running_process_i (running_process_o),
    .result_index_i    (result_index_o),
    .caller_blocked_i  (caller_blocked_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: ready is redrawn every falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Drives one item. Starts on a falling edge, optionally holds off, then keeps
  // valid and payload steady until the item is taken at a rising edge. Valid is
  // left high on return so back-to-back items need no extra cycle.
  task automatic issue_syscall(op_e op, logic [2:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    sem_index_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // lower valid and wait until every outstanding result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // register write; only called once the block is idle
  task automatic set_first_user(logic [2:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // semaphore index: mostly the low, likely allocated ones, sometimes any
  function automatic logic [2:0] pick_sem();
    return $urandom_range(1) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
  endfunction

  // single op, weighted toward schedule and P/V traffic; exit and wait kept
  // rare since they retire processes for good
  task automatic lone_syscall();
    int unsigned r;
    op_e         op;
    r = $urandom_range(99);
    if (r < 30)      op = OP_SCHEDULE;
    else if (r < 33) op = OP_FORK;
    else if (r < 38) op = OP_WAIT;
    else if (r < 43) op = OP_EXIT;
    else if (r < 50) op = OP_GETSEM;
    else if (r < 72) op = OP_SEM_P;
    else if (r < 94) op = OP_SEM_V;
    else             op = OP_FREE;
    issue_syscall(op, pick_sem());
  endtask

  // one random sequence: mostly well-formed P/schedule/V exchanges, plus
  // allocation streaks, count saturation both ways and plain noise
  task automatic random_sequence();
    int unsigned r;
    int unsigned n;
    logic [2:0]  s;
    r = $urandom_range(99);
    s = pick_sem();
    if (r < 45) begin
      lone_syscall();
    end else if (r < 70) begin
      // each P blocks the runner and hands the CPU on; V's wake them in order
      n = $urandom_range(1, 5);
      repeat (n) begin
        issue_syscall(OP_SEM_P, s);
        issue_syscall(OP_SCHEDULE, 3'($urandom_range(7)));
      end
      repeat (n) begin
        issue_syscall(OP_SEM_V, s);
        if ($urandom_range(1)) issue_syscall(OP_SCHEDULE, 3'($urandom_range(7)));
      end
    end else if (r < 80) begin
      // allocation streak, long enough at times to run out of semaphores
      repeat ($urandom_range(3, 9)) issue_syscall(OP_GETSEM, 3'($urandom_range(7)));
      repeat ($urandom_range(1, 4)) issue_syscall(OP_FREE, 3'($urandom_range(7)));
    end else if (r < 87) begin
      // drive the count to its floor with the ring overflowing, then back up
      issue_syscall(OP_FREE, s);
      repeat (18) issue_syscall(OP_SEM_P, s);
      repeat (18) issue_syscall(OP_SEM_V, s);
      issue_syscall(OP_SCHEDULE, s);
    end else if (r < 93) begin
      // count ceiling
      issue_syscall(OP_FREE, s);
      repeat (17) issue_syscall(OP_SEM_V, s);
      issue_syscall(OP_SEM_P, s);
      issue_syscall(OP_FREE, s);
    end else begin
      issue_syscall(OP_WAIT, s);
      issue_syscall(OP_SCHEDULE, s);
      issue_syscall(OP_EXIT, s);
      issue_syscall(OP_SCHEDULE, s);
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    op_i        = OP_SCHEDULE;
    sem_index_i = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Range above the highest process (still 2 after reset): empty range
    set_first_user(3'd7);
    issue_syscall(OP_SCHEDULE, 3'd0);
    drain();
    set_first_user(3'd1);

    // Directed: scheduling, forking up to a full table, semaphore traffic
    // including an unused one, wait and exit.
    issue_syscall(OP_SCHEDULE, 3'd0);
    issue_syscall(OP_SCHEDULE, 3'd0);
    repeat (5) issue_syscall(OP_FORK, 3'd0);
    issue_syscall(OP_FORK, 3'd7);           // table full
    issue_syscall(OP_GETSEM, 3'd5);
    issue_syscall(OP_SEM_P, 3'd0);          // blocks the runner
    issue_syscall(OP_SCHEDULE, 3'd0);
    issue_syscall(OP_SEM_V, 3'd0);          // wakes it
    issue_syscall(OP_SEM_V, 3'd7);          // semaphore never allocated
    issue_syscall(OP_SEM_P, 3'd7);
    issue_syscall(OP_GETSEM, 3'd2);
    issue_syscall(OP_FREE, 3'd0);
    issue_syscall(OP_WAIT, 3'd3);
    issue_syscall(OP_EXIT, 3'd4);           // readies the parent
    issue_syscall(OP_SCHEDULE, 3'd6);
    issue_syscall(OP_FREE, 3'd7);
    issue_syscall(OP_SCHEDULE, 3'd1);
    n_directed = sent;

    // Random: six segments of ~75 items, each with its own range start.
    // Pacing: sender-light/receiver-heavy, then reversed, then none.
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      gap_pct   = (seg < 2) ? 33 : (seg < 4) ? 77 : 0;
      stall_pct = (seg < 2) ? 77 : (seg < 4) ? 33 : 0;
      set_first_user(fup_plan[seg]);
      while (sent < n_directed + (seg + 1) * 75) random_sequence();
    end

    drain();
    repeat (40) @(negedge clk_i);

    $display("Sent %0d operations (%0d directed) over six first-process settings,",
             sent, n_directed);
    $display("with sender/receiver idling at 33/77, 77/33 and none.");
    if (fail_count == 0 && pending == 0) begin
      $display("** process_table_scheduler_semaphores_unit: PASSED **");
    end else begin
      $display("** process_table_scheduler_semaphores_unit: FAILED **");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("** process_table_scheduler_semaphores_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hdl/ptss_pkg.sv
hdl/process_table_scheduler_semaphores_unit.sv
hdl/ptss_checker.sv
test/process_table_scheduler_semaphores_unit_checker.sv
test/process_table_scheduler_semaphores_unit_tb.sv
